### hw/rtl/mhpq_pkg.sv
// Package with the item types, codes and controller command types of the min-heap queue.
package mhpq_pkg;

   localparam int ValueWidth    = 32;
   localparam int PriorityWidth = 32;
   localparam int OccWidth      = 11;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      opcode_type               opcode;
      logic [ValueWidth-1:0]    item_value;
      logic [PriorityWidth-1:0] item_priority;
   } req_type;

   typedef struct packed {
      logic [ValueWidth-1:0] popped_value;
      status_type            status;
      logic [OccWidth-1:0]   occupancy;
      logic                  is_empty;
      logic [ValueWidth-1:0] top_value;
   } rsp_type;

   typedef struct packed {
      logic [ValueWidth-1:0]    value;
      logic [PriorityWidth-1:0] prio;
   } entry_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_UP_CHK,
      S_UP_CMP,
      S_LAST,
      S_DN_CHK,
      S_DN_RD,
      S_DN_CMP,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      RD_NONE,
      RD_PARENT,
      RD_LAST,
      RD_LEFT,
      RD_RIGHT
   } rd_sel_type;

   typedef enum logic [1:0] {
      WR_CUR,
      WR_MOVED,
      WR_PICK
   } wr_sel_type;

   typedef enum logic [1:0] {
      POS_HOLD,
      POS_ROOT,
      POS_PARENT,
      POS_PICK
   } pos_sel_type;

   typedef struct packed {
      logic        accept;
      rd_sel_type  rd_sel;
      logic        wr_en;
      wr_sel_type  wr_sel;
      pos_sel_type pos_sel;
      logic        load_cur;
      logic        load_child;
      logic        load_rsp;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
      logic pos_root;
      logic lc_out;
      logic rc_out;
      logic up_stop;
      logic dn_swap;
   } sts_type;

endpackage

### hw/rtl/mhpq_datapath.sv
// Datapath of the min-heap queue: heap memory, entry count, sift registers and result register.
module mhpq_datapath #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  mhpq_pkg::req_type req_data,
   input  mhpq_pkg::cmd_type cmd,
   output mhpq_pkg::sts_type sts,
   output mhpq_pkg::rsp_type rsp_data
);

   localparam int CntW = $clog2(CAPACITY + 1);
   localparam int IdxW = $clog2(CAPACITY);

   mhpq_pkg::entry_type heap_ff [CAPACITY];
   mhpq_pkg::entry_type rd_data_ff;
   mhpq_pkg::entry_type cur_ff, cur_in;
   mhpq_pkg::entry_type child_ff;
   mhpq_pkg::entry_type pick_ent;
   mhpq_pkg::entry_type wr_ent;
   mhpq_pkg::rsp_type   rsp_data_ff;
   mhpq_pkg::status_type status_ff, status_in;

   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] pos_ff, pos_in;
   logic [CntW-1:0] child_pos_ff;
   logic [CntW-1:0] pick_pos;
   logic [CntW-1:0] rd_pos, rd_off, wr_off;
   logic [CntW:0]   lc_wide, rc_wide, cnt_wide;
   logic [IdxW-1:0] rd_idx, wr_idx;
   logic            rd_en;
   logic            rc_ok_ff;
   logic            pick_right;
   logic            full, empty;
   logic [mhpq_pkg::ValueWidth-1:0] root_val_ff;
   logic [mhpq_pkg::ValueWidth-1:0] popped_ff, popped_in;

   assign full     = (count_ff == CntW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign lc_wide  = {pos_ff, 1'b0};
   assign rc_wide  = (CntW+1)'(lc_wide + 1'b1);
   assign cnt_wide = {1'b0, count_ff};

   assign pick_right = rc_ok_ff && (rd_data_ff.prio < child_ff.prio);
   assign pick_ent   = pick_right ? rd_data_ff : child_ff;
   assign pick_pos   = pick_right ? CntW'(child_pos_ff + 1'b1) : child_pos_ff;

   assign sts.full     = full;
   assign sts.empty    = empty;
   assign sts.pos_root = (pos_ff == CntW'(1));
   assign sts.lc_out   = (lc_wide > cnt_wide);
   assign sts.rc_out   = (rc_wide > cnt_wide);
   assign sts.up_stop  = (rd_data_ff.prio <= cur_ff.prio);
   assign sts.dn_swap  = (pick_ent.prio < cur_ff.prio);

   always_comb begin
      rd_en  = 1'b1;
      rd_pos = pos_ff;
      case (cmd.rd_sel)
         mhpq_pkg::RD_PARENT: rd_pos = pos_ff >> 1;
         mhpq_pkg::RD_LAST:   rd_pos = count_ff;
         mhpq_pkg::RD_LEFT:   rd_pos = lc_wide[CntW-1:0];
         mhpq_pkg::RD_RIGHT:  rd_pos = rc_wide[CntW-1:0];
         default:             rd_en  = 1'b0;
      endcase
   end

   assign rd_off = CntW'(rd_pos - 1'b1);
   assign rd_idx = rd_off[IdxW-1:0];
   assign wr_off = CntW'(pos_ff - 1'b1);
   assign wr_idx = wr_off[IdxW-1:0];

   always_comb begin
      case (cmd.wr_sel)
         mhpq_pkg::WR_MOVED: wr_ent = rd_data_ff;
         mhpq_pkg::WR_PICK:  wr_ent = pick_ent;
         default:            wr_ent = cur_ff;
      endcase
   end

   always_comb begin
      count_in  = count_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      if (cmd.accept) begin
         cur_in.value = req_data.item_value;
         cur_in.prio  = req_data.item_priority;
         popped_in    = '0;
         status_in    = mhpq_pkg::STATUS_OK;
         if (req_data.opcode == mhpq_pkg::OP_PUSH) begin
            pos_in = CntW'(count_ff + 1'b1);
            if (full) begin
               status_in = mhpq_pkg::STATUS_FULL;
            end else begin
               count_in = CntW'(count_ff + 1'b1);
            end
         end else begin
            if (empty) begin
               status_in = mhpq_pkg::STATUS_EMPTY;
            end else begin
               popped_in = root_val_ff;
               count_in  = CntW'(count_ff - 1'b1);
            end
         end
      end else begin
         if (cmd.load_cur) begin
            cur_in = rd_data_ff;
         end
         case (cmd.pos_sel)
            mhpq_pkg::POS_ROOT:   pos_in = CntW'(1);
            mhpq_pkg::POS_PARENT: pos_in = pos_ff >> 1;
            mhpq_pkg::POS_PICK:   pos_in = pick_pos;
            default:              pos_in = pos_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff    <= pos_in;
      cur_ff    <= cur_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
      if (cmd.load_child) begin
         child_ff     <= rd_data_ff;
         child_pos_ff <= lc_wide[CntW-1:0];
         rc_ok_ff     <= !sts.rc_out;
      end
      if (cmd.wr_en && (pos_ff == CntW'(1))) begin
         root_val_ff <= wr_ent.value;
      end
      if (cmd.load_rsp) begin
         rsp_data_ff.popped_value <= popped_ff;
         rsp_data_ff.status       <= status_ff;
         rsp_data_ff.occupancy    <= mhpq_pkg::OccWidth'(count_ff);
         rsp_data_ff.is_empty     <= empty;
         rsp_data_ff.top_value    <= empty ? '0 : root_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         heap_ff[wr_idx] <= wr_ent;
      end
      if (rd_en) begin
         rd_data_ff <= heap_ff[rd_idx];
      end
   end

   assign rsp_data = rsp_data_ff;

endmodule

### hw/rtl/mhpq_controller.sv
// Controller state machine of the min-heap queue: sequences sift-up and sift-down steps.
module mhpq_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  mhpq_pkg::opcode_type req_opcode,
   input  logic                 rsp_stall,
   input  mhpq_pkg::sts_type    sts,
   output mhpq_pkg::cmd_type    cmd,
   output logic                 req_stall,
   output logic                 rsp_valid
);

   mhpq_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_free;

   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mhpq_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_opcode == mhpq_pkg::OP_PUSH) begin
                  state_in = sts.full ? mhpq_pkg::S_FINISH : mhpq_pkg::S_UP_CHK;
               end else begin
                  state_in = sts.empty ? mhpq_pkg::S_FINISH : mhpq_pkg::S_LAST;
               end
            end
         end
         mhpq_pkg::S_UP_CHK: begin
            state_in = sts.pos_root ? mhpq_pkg::S_FINISH : mhpq_pkg::S_UP_CMP;
         end
         mhpq_pkg::S_UP_CMP: begin
            state_in = sts.up_stop ? mhpq_pkg::S_FINISH : mhpq_pkg::S_UP_CHK;
         end
         mhpq_pkg::S_LAST: begin
            state_in = sts.empty ? mhpq_pkg::S_FINISH : mhpq_pkg::S_DN_CHK;
         end
         mhpq_pkg::S_DN_CHK: begin
            state_in = sts.lc_out ? mhpq_pkg::S_FINISH : mhpq_pkg::S_DN_RD;
         end
         mhpq_pkg::S_DN_RD: begin
            state_in = mhpq_pkg::S_DN_CMP;
         end
         mhpq_pkg::S_DN_CMP: begin
            state_in = sts.dn_swap ? mhpq_pkg::S_DN_CHK : mhpq_pkg::S_FINISH;
         end
         mhpq_pkg::S_FINISH: begin
            if (rsp_free) begin
               state_in = mhpq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mhpq_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.rd_sel     = mhpq_pkg::RD_NONE;
      cmd.wr_sel     = mhpq_pkg::WR_CUR;
      cmd.pos_sel    = mhpq_pkg::POS_HOLD;
      case (state_ff)
         mhpq_pkg::S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && (req_opcode == mhpq_pkg::OP_POP) && !sts.empty) begin
               cmd.rd_sel = mhpq_pkg::RD_LAST;
            end
         end
         mhpq_pkg::S_UP_CHK: begin
            if (sts.pos_root) begin
               cmd.wr_en = 1'b1;
            end else begin
               cmd.rd_sel = mhpq_pkg::RD_PARENT;
            end
         end
         mhpq_pkg::S_UP_CMP: begin
            cmd.wr_en = 1'b1;
            if (!sts.up_stop) begin
               cmd.wr_sel  = mhpq_pkg::WR_MOVED;
               cmd.pos_sel = mhpq_pkg::POS_PARENT;
            end
         end
         mhpq_pkg::S_LAST: begin
            cmd.load_cur = 1'b1;
            cmd.pos_sel  = mhpq_pkg::POS_ROOT;
         end
         mhpq_pkg::S_DN_CHK: begin
            if (sts.lc_out) begin
               cmd.wr_en = 1'b1;
            end else begin
               cmd.rd_sel = mhpq_pkg::RD_LEFT;
            end
         end
         mhpq_pkg::S_DN_RD: begin
            cmd.load_child = 1'b1;
            if (!sts.rc_out) begin
               cmd.rd_sel = mhpq_pkg::RD_RIGHT;
            end
         end
         mhpq_pkg::S_DN_CMP: begin
            cmd.wr_en = 1'b1;
            if (sts.dn_swap) begin
               cmd.wr_sel  = mhpq_pkg::WR_PICK;
               cmd.pos_sel = mhpq_pkg::POS_PICK;
            end
         end
         mhpq_pkg::S_FINISH: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != mhpq_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue with fixed capacity.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  mhpq_pkg::req_type
//   rsp      out        rsp_valid / rsp_stall  mhpq_pkg::rsp_type
//
// A push sifts up and a pop sifts down the heap level by level, over up to log2 of CAPACITY
// levels; the single heap memory with registered read data sets the pace of each level.
// Reset clears the entry count and the controller; heap contents are not cleared.
// One item is in work at a time; a finished result waits in the output register while
// rsp_stall is high, and the next item is accepted meanwhile.
module min_heap_priority_queue #(
   parameter int CAPACITY = 1024
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mhpq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mhpq_pkg::rsp_type rsp_data
);

   mhpq_pkg::cmd_type cmd;
   mhpq_pkg::sts_type sts;

   mhpq_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid)
   );

   mhpq_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block not busy after accepting an item");

   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in work");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == mhpq_pkg::STATUS_EMPTY))
         |-> (rsp_data.is_empty && (rsp_data.popped_value == '0)))
      else $error("failed pop reported a stored entry");

   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == mhpq_pkg::STATUS_FULL)) |-> !rsp_data.is_empty)
      else $error("rejected push reported an empty heap");

endmodule

### sim/testbench.sv
// Self-checking testbench for the min-heap priority queue, with a shadow heap predicting each item.
module testbench;

   localparam int Capacity   = 1024;
   localparam int CycleLimit = 1000000;
   localparam int TotalItems = 1750;
   localparam int QuietFirst = 600;
   localparam int QuietLast  = 900;
   localparam int HoldCycles = 300;
   localparam int TailCycles = 60;

   typedef struct packed {
      mhpq_pkg::req_type item;
      bit                typed;
      mhpq_pkg::rsp_type want;
   } stim_row_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   mhpq_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   mhpq_pkg::rsp_type rsp_data;

   mhpq_pkg::entry_type shadow_heap [1:Capacity];
   int                  shadow_count = 0;
   mhpq_pkg::rsp_type   pending_heap_results [$];
   stim_row_type        directed_rows [$];
   int                  items_sent = 0;
   int                  error_count = 0;

   min_heap_priority_queue #(
      .CAPACITY(Capacity)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic mhpq_pkg::rsp_type next_heap_result(input mhpq_pkg::req_type item);
      mhpq_pkg::rsp_type   result;
      mhpq_pkg::entry_type held;
      int                  pos;
      int                  kid;
      bit                  settled;
      result = '0;
      result.status = mhpq_pkg::STATUS_OK;
      if (item.opcode == mhpq_pkg::OP_PUSH) begin
         if (shadow_count >= Capacity) begin
            result.status = mhpq_pkg::STATUS_FULL;
         end else begin
            shadow_count++;
            shadow_heap[shadow_count].value = item.item_value;
            shadow_heap[shadow_count].prio = item.item_priority;
            pos = shadow_count;
            while (pos > 1 && shadow_heap[pos / 2].prio > shadow_heap[pos].prio) begin
               held = shadow_heap[pos];
               shadow_heap[pos] = shadow_heap[pos / 2];
               shadow_heap[pos / 2] = held;
               pos = pos / 2;
            end
         end
      end else if (shadow_count == 0) begin
         result.status = mhpq_pkg::STATUS_EMPTY;
      end else begin
         result.popped_value = shadow_heap[1].value;
         shadow_heap[1] = shadow_heap[shadow_count];
         shadow_count--;
         pos = 1;
         settled = 1'b0;
         while (!settled && 2 * pos <= shadow_count) begin
            kid = 2 * pos;
            if (kid + 1 <= shadow_count && shadow_heap[kid + 1].prio < shadow_heap[kid].prio) begin
               kid++;
            end
            if (shadow_heap[kid].prio < shadow_heap[pos].prio) begin
               held = shadow_heap[pos];
               shadow_heap[pos] = shadow_heap[kid];
               shadow_heap[kid] = held;
               pos = kid;
            end else begin
               settled = 1'b1;
            end
         end
      end
      result.occupancy = mhpq_pkg::OccWidth'(shadow_count);
      result.is_empty = (shadow_count == 0);
      result.top_value = (shadow_count == 0) ? '0 : shadow_heap[1].value;
      return result;
   endfunction

   function automatic void add_row(input mhpq_pkg::opcode_type op, input logic [31:0] value,
                                   input logic [31:0] prio, input bit typed,
                                   input logic [31:0] popped,
                                   input mhpq_pkg::status_type status,
                                   input int occupancy, input bit empty,
                                   input logic [31:0] top);
      stim_row_type row;
      row.item.opcode = op;
      row.item.item_value = value;
      row.item.item_priority = prio;
      row.typed = typed;
      row.want.popped_value = popped;
      row.want.status = status;
      row.want.occupancy = mhpq_pkg::OccWidth'(occupancy);
      row.want.is_empty = empty;
      row.want.top_value = top;
      directed_rows.push_back(row);
   endfunction

   function automatic mhpq_pkg::req_type random_item(input int push_pct);
      mhpq_pkg::req_type item;
      item.opcode = ($urandom_range(99) < push_pct) ? mhpq_pkg::OP_PUSH : mhpq_pkg::OP_POP;
      item.item_value = $urandom();
      case ($urandom_range(3))
         0: item.item_priority = $urandom_range(15);
         1: item.item_priority = ($urandom_range(1) != 0) ? 32'hFFFF_FFFF : 32'h0;
         default: item.item_priority = $urandom();
      endcase
      return item;
   endfunction

   task automatic send_item(input mhpq_pkg::req_type item, input bit typed,
                            input mhpq_pkg::rsp_type want);
      mhpq_pkg::rsp_type predicted;
      predicted = next_heap_result(item);
      pending_heap_results.push_back(typed ? want : predicted);
      while (!(items_sent >= QuietFirst && items_sent < QuietLast)
             && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      items_sent++;
   endtask

   task automatic await_outstanding_results();
      req_valid <= 1'b0;
      while (pending_heap_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin : result_checker
      mhpq_pkg::rsp_type want;
      int                results_seen;
      int                hold_left;
      bit                held_once;
      results_seen = 0;
      hold_left = 0;
      held_once = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_heap_results.size() == 0) begin
               $display("%0t: result with no item pending: popped %h status %0d occupancy %0d",
                        $time, rsp_data.popped_value, rsp_data.status, rsp_data.occupancy);
               error_count++;
            end else begin
               want = pending_heap_results.pop_front();
               if (rsp_data.popped_value !== want.popped_value) begin
                  $display("%0t: popped_value expected %h, got %h", $time,
                           want.popped_value, rsp_data.popped_value);
                  error_count++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time,
                           want.status, rsp_data.status);
                  error_count++;
               end
               if (rsp_data.occupancy !== want.occupancy) begin
                  $display("%0t: occupancy expected %0d, got %0d", $time,
                           want.occupancy, rsp_data.occupancy);
                  error_count++;
               end
               if (rsp_data.is_empty !== want.is_empty) begin
                  $display("%0t: is_empty expected %b, got %b", $time,
                           want.is_empty, rsp_data.is_empty);
                  error_count++;
               end
               if (rsp_data.top_value !== want.top_value) begin
                  $display("%0t: top_value expected %h, got %h", $time,
                           want.top_value, rsp_data.top_value);
                  error_count++;
               end
            end
            results_seen++;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (!held_once && results_seen >= 100) begin
            held_once = 1'b1;
            hold_left = HoldCycles;
            rsp_stall <= 1'b1;
         end else if (results_seen >= QuietFirst && results_seen < QuietLast) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < 10);
         end
      end
   end

   initial begin : stimulus
      int i;
      add_row(mhpq_pkg::OP_POP,  32'h0,         32'h0,         1'b1,
              32'h0,         mhpq_pkg::STATUS_EMPTY, 0, 1'b1, 32'h0);
      add_row(mhpq_pkg::OP_POP,  32'h0,         32'h0,         1'b1,
              32'h0,         mhpq_pkg::STATUS_EMPTY, 0, 1'b1, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
              32'h0,         mhpq_pkg::STATUS_OK,    1, 1'b0, 32'hFFFF_FFFF);
      add_row(mhpq_pkg::OP_POP,  32'h0,         32'h0,         1'b1,
              32'hFFFF_FFFF, mhpq_pkg::STATUS_OK,    0, 1'b1, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'h0,         32'h0,         1'b1,
              32'h0,         mhpq_pkg::STATUS_OK,    1, 1'b0, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'h1,         32'h0,         1'b1,
              32'h0,         mhpq_pkg::STATUS_OK,    2, 1'b0, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'h2,         32'h0,         1'b1,
              32'h0,         mhpq_pkg::STATUS_OK,    3, 1'b0, 32'h0);
      add_row(mhpq_pkg::OP_POP,  32'h0,         32'h0,         1'b0,
              32'h0,         mhpq_pkg::STATUS_OK,    0, 1'b0, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b0,
              32'h0,         mhpq_pkg::STATUS_OK,    0, 1'b0, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'h5555_5555, 32'h8000_0000, 1'b0,
              32'h0,         mhpq_pkg::STATUS_OK,    0, 1'b0, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'h1234_5678, 32'h7FFF_FFFF, 1'b0,
              32'h0,         mhpq_pkg::STATUS_OK,    0, 1'b0, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'hDEAD_BEEF, 32'h0000_0001, 1'b0,
              32'h0,         mhpq_pkg::STATUS_OK,    0, 1'b0, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'hCAFE_F00D, 32'h0,         1'b0,
              32'h0,         mhpq_pkg::STATUS_OK,    0, 1'b0, 32'h0);
      add_row(mhpq_pkg::OP_PUSH, 32'h0F0F_0F0F, 32'hFFFF_FFFE, 1'b0,
              32'h0,         mhpq_pkg::STATUS_OK,    0, 1'b0, 32'h0);
      for (i = 0; i < 8; i++) begin
         add_row(mhpq_pkg::OP_POP, 32'h0, 32'h0, 1'b0,
                 32'h0, mhpq_pkg::STATUS_OK, 0, 1'b0, 32'h0);
      end
      add_row(mhpq_pkg::OP_POP,  32'h0,         32'h0,         1'b1,
              32'h0,         mhpq_pkg::STATUS_EMPTY, 0, 1'b1, 32'h0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[row]) begin
         send_item(directed_rows[row].item, directed_rows[row].typed, directed_rows[row].want);
      end

      // Mixed traffic that leaves a shallow heap behind, including pops on empty.
      for (i = 0; i < 200; i++) begin
         send_item(random_item(70), 1'b0, '0);
      end
      await_outstanding_results();

      // Fill to capacity, then check rejection at full and recovery after one pop.
      while (shadow_count < Capacity) begin
         send_item(random_item(100), 1'b0, '0);
      end
      for (i = 0; i < 5; i++) begin
         send_item(random_item(100), 1'b0, '0);
      end
      send_item(random_item(0), 1'b0, '0);
      for (i = 0; i < 3; i++) begin
         send_item(random_item(100), 1'b0, '0);
      end

      // Pop-heavy traffic takes entries out of the deep heap.
      while (items_sent < TotalItems) begin
         send_item(random_item(25), 1'b0, '0);
      end

      await_outstanding_results();
      repeat (TailCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
